### sv/rse_pkg.sv
// Shared constants and types for the RGB Sobel edge stream.
`default_nettype none
package rse_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int HEIGHT_LIMIT = 1024;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
   localparam int DIM_W        = 11;
   localparam int PIX_W        = 8;
   localparam int DIFF_W       = 11;
   localparam int CSR_IDX_W    = 1;

   localparam logic [DIM_W-1:0] MIN_DIM       = DIM_W'(3);
   localparam logic [DIM_W-1:0] MAX_DIM_W     = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] MAX_DIM_H     = DIM_W'(HEIGHT_LIMIT);
   localparam logic [DIM_W-1:0] RESET_WIDTH   = DIM_W'(640);
   localparam logic [DIM_W-1:0] RESET_HEIGHT  = DIM_W'(480);
   localparam logic [PIX_W-1:0] SAT_MAX       = PIX_W'(255);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef logic [PIX_W-1:0] pixel_type;

   typedef struct packed {
      logic               has_result;
      logic               last;
      logic [COL_W-1:0]   column;
      pixel_type          gray;
   } stage_type;

endpackage
`default_nettype wire

### sv/rse_stream_if.sv
// Valid/ready channel interfaces for pixels in and edge results out.
`default_nettype none
interface rse_pixel_if;
   import rse_pkg::*;
   logic      valid;
   logic      ready;
   pixel_type red;
   pixel_type green;
   pixel_type blue;
   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface rse_edge_if;
   import rse_pkg::*;
   logic      valid;
   logic      ready;
   pixel_type edge_value;
   logic      frame_last;
   modport source (output valid, output edge_value, output frame_last, input ready);
   modport sink (input valid, input edge_value, input frame_last, output ready);
endinterface
`default_nettype wire

### sv/rgb_sobel_edge_stream.sv
// Each pixel is registered in stage 1; its result enters the output register when stage 1 advances.
// Throughput: one pixel per cycle; the input stalls only while a finished result waits.
// Rate is set by the line-store read ports, each store read once per pixel at its column.
// Reset clears the counters, window and valid flags, and sets the size registers (640 x 480).
// The line stores are not cleared; entries are written before any result uses them.
`default_nettype none
module rgb_sobel_edge_stream (
   input  wire                               clock,
   input  wire                               reset,
   rse_pixel_if.sink                         req,
   rse_edge_if.source                        rsp,
   input  wire                               csr_write_enable,
   input  wire [rse_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [rse_pkg::DIM_W-1:0]          csr_write_data
);
   import rse_pkg::*;

   // size registers
   logic [DIM_W-1:0] frame_width_ff, frame_height_ff;
   logic [DIM_W-1:0] width_eff, height_eff;

   // counters and stage
   logic [COL_W-1:0] column_ff, column_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             s1_valid_ff;
   stage_type        s1_ff, s1_in;
   logic             accept, advance;

   // line stores
   pixel_type        line_upper [MAX_WIDTH];
   pixel_type        line_middle [MAX_WIDTH];
   pixel_type        up_rd_ff, mid_rd_ff;

   // window: upper c-2, c-1; middle c-2, c-1; current c-1
   pixel_type        win_u0_ff, win_u1_ff, win_m0_ff, win_m1_ff, win_c1_ff;

   // output register
   logic             out_valid_ff;
   pixel_type        edge_ff, edge_in;
   logic             last_ff;

   logic signed [DIFF_W-1:0] diff;
   logic        [DIFF_W-1:0] mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= RESET_WIDTH;
         frame_height_ff <= RESET_HEIGHT;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_write_data;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      width_eff = frame_width_ff;
      if (frame_width_ff < MIN_DIM) width_eff = MIN_DIM;
      else if (frame_width_ff > MAX_DIM_W) width_eff = MAX_DIM_W;
      height_eff = frame_height_ff;
      if (frame_height_ff < MIN_DIM) height_eff = MIN_DIM;
      else if (frame_height_ff > MAX_DIM_H) height_eff = MAX_DIM_H;
   end

   // stage 1 moves on unless its result would collide with a waiting one
   assign advance   = s1_valid_ff && (!s1_ff.has_result || !out_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || advance;
   assign accept    = req.valid && req.ready;

   always_comb begin
      logic [DIM_W-1:0] col_x, row_x;
      col_x = DIM_W'(column_ff);
      row_x = DIM_W'(row_ff);
      s1_in.gray = PIX_W'({3'b000, req.red[7:3]}) + PIX_W'({1'b0, req.green[7:1]})
                 + PIX_W'({2'b00, req.blue[7:2]});
      s1_in.column     = column_ff;
      s1_in.has_result = (col_x < width_eff) && (row_x < height_eff)
                         && (col_x >= DIM_W'(2)) && (row_x >= DIM_W'(2));
      s1_in.last       = (col_x == width_eff - DIM_W'(1))
                         && (row_x == height_eff - DIM_W'(1));
      column_in = column_ff + COL_W'(1);
      row_in    = row_ff;
      // wrap at the end of a row, and at the end of the frame
      if (col_x + DIM_W'(1) >= width_eff) begin
         column_in = '0;
         if (row_x + DIM_W'(1) >= height_eff) row_in = '0;
         else row_in = row_ff + ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff   <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            column_ff <= column_in;
            row_ff    <= row_in;
         end
         if (accept) s1_valid_ff <= 1'b1;
         else if (advance) s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) s1_ff <= s1_in;
   end

   // read at transfer; write back when stage 1 advances, never at the same column
   always_ff @(posedge clock) begin
      if (accept) begin
         up_rd_ff  <= line_upper[column_ff];
         mid_rd_ff <= line_middle[column_ff];
      end
      if (advance) begin
         line_upper[s1_ff.column]  <= mid_rd_ff;
         line_middle[s1_ff.column] <= s1_ff.gray;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_u0_ff <= '0;
         win_u1_ff <= '0;
         win_m0_ff <= '0;
         win_m1_ff <= '0;
         win_c1_ff <= '0;
      end else if (advance) begin
         win_u0_ff <= win_u1_ff;
         win_u1_ff <= up_rd_ff;
         win_m0_ff <= win_m1_ff;
         win_m1_ff <= mid_rd_ff;
         win_c1_ff <= s1_ff.gray;
      end
   end

   always_comb begin
      diff = $signed(DIFF_W'(win_u0_ff)) + $signed(DIFF_W'(win_u1_ff))
           - $signed(DIFF_W'(win_c1_ff)) - $signed(DIFF_W'(s1_ff.gray))
           + $signed(DIFF_W'(win_m0_ff)) - $signed(DIFF_W'(mid_rd_ff));
      mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      // doubling saturates once the magnitude passes 127
      if (mag > DIFF_W'(127)) edge_in = SAT_MAX;
      else edge_in = {mag[6:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && s1_ff.has_result) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_ff.has_result) begin
         edge_ff <= edge_in;
         last_ff <= s1_ff.last;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.edge_value = edge_ff;
   assign rsp.frame_last = last_ff;

endmodule
`default_nettype wire
